FILE: rtl/battery_charge_state_controller_macros.svh
// Assertion macros for the battery charge state controller.
`ifndef BATTERY_CHARGE_STATE_CONTROLLER_MACROS_SVH
`define BATTERY_CHARGE_STATE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define BCSC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bcsc assertion failed");
`define BCSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bcsc assertion failed");
`else
`define BCSC_ASSERT(label, clk, rstn, prop)
`define BCSC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/bcsc_pkg.sv
// Types and constants of the battery charge state controller.
package bcsc_pkg;

    localparam int CELL_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CURRENT_W   = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_MASK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_DET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_STOP  = 3'd5;

    localparam logic [15:0]          RST_CRIT_MASK    = 16'hFFFE;
    localparam logic [15:0]          RST_LINK_MASK    = 16'h0001;
    localparam logic [15:0]          RST_CELL_MIN     = 16'd2500;
    localparam logic [15:0]          RST_CELL_MAX     = 16'd4300;
    localparam logic [14:0]          RST_CHARGE_DET   = 15'd100;
    localparam logic [14:0]          RST_CHARGE_STOP  = 15'd30;

    typedef enum logic [2:0] {
        ST_INIT        = 3'd0,
        ST_SELF_CHECK  = 3'd1,
        ST_IDLE        = 3'd2,
        ST_CHARGE_READY = 3'd3,
        ST_CHARGING    = 3'd4,
        ST_FAULT       = 3'd5
    } state_t;

    typedef struct packed {
        logic [15:0]              fault_flags;
        logic                     charge_request;
        logic                     charger_connected;
        logic                     emergency_stop;
        logic                     sensors_ready;
        logic signed [15:0]       pack_current_ma;
        logic [63:0]              cell_voltages;
        logic                     permit_request;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               fsm_state;
        logic                     permit_granted;
    } out_item_t;

    typedef struct packed {
        logic [15:0]              critical_fault_mask;
        logic [15:0]              link_timeout_mask;
        logic [CELL_W-1:0]        cell_min_mv;
        logic [CELL_W-1:0]        cell_max_mv;
        logic [CURRENT_W-1:0]     charge_on_ma;
        logic [CURRENT_W-1:0]     charge_off_ma;
    } cfg_t;

endpackage

FILE: rtl/battery_charge_state_controller.sv
// Battery charge state controller top level: config registers, lanes, FSM, output skid.
// Each result is registered in the output register, or in the skid entry while m_ready is low.
// Throughput: one item per cycle while the skid entry is empty; s_ready is low while it holds a result.
// A two-entry output buffer keeps s_ready high while one result waits on m_ready.
// Reset (synchronous, aresetn low): state to init, registers to defaults, buffer empty.
`include "battery_charge_state_controller_macros.svh"

module battery_charge_state_controller #(
    parameter int CELL_COUNT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bcsc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bcsc_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bcsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bcsc_pkg::cfg_t       cfg_reg;
    bcsc_pkg::cfg_t       cfg_next;
    bcsc_pkg::out_item_t  result;
    bcsc_pkg::out_item_t  out_reg;
    bcsc_pkg::out_item_t  out_next;
    bcsc_pkg::out_item_t  skid_reg;
    bcsc_pkg::out_item_t  skid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic                 accept_in;
    logic [CELL_COUNT-1:0] lane_ok;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept_in = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bcsc_pkg::CFG_CRIT_MASK:   cfg_next.critical_fault_mask = cfg_data;
                bcsc_pkg::CFG_LINK_MASK:   cfg_next.link_timeout_mask   = cfg_data;
                bcsc_pkg::CFG_CELL_MIN:    cfg_next.cell_min_mv         = cfg_data;
                bcsc_pkg::CFG_CELL_MAX:    cfg_next.cell_max_mv         = cfg_data;
                bcsc_pkg::CFG_CHARGE_DET:
                    cfg_next.charge_on_ma  = cfg_data[bcsc_pkg::CURRENT_W-1:0];
                bcsc_pkg::CFG_CHARGE_STOP:
                    cfg_next.charge_off_ma = cfg_data[bcsc_pkg::CURRENT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.critical_fault_mask <= bcsc_pkg::RST_CRIT_MASK;
            cfg_reg.link_timeout_mask   <= bcsc_pkg::RST_LINK_MASK;
            cfg_reg.cell_min_mv         <= bcsc_pkg::RST_CELL_MIN;
            cfg_reg.cell_max_mv         <= bcsc_pkg::RST_CELL_MAX;
            cfg_reg.charge_on_ma        <= bcsc_pkg::RST_CHARGE_DET;
            cfg_reg.charge_off_ma       <= bcsc_pkg::RST_CHARGE_STOP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_lane
        bcsc_cell_lane u_lane (
            .cell_mv   (s_data.cell_voltages[bcsc_pkg::CELL_W*i +: bcsc_pkg::CELL_W]),
            .min_mv    (cfg_reg.cell_min_mv),
            .max_mv    (cfg_reg.cell_max_mv),
            .in_window (lane_ok[i])
        );
    end

    bcsc_fsm #(
        .CELL_COUNT (CELL_COUNT)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (accept_in),
        .item    (s_data),
        .cfg     (cfg_reg),
        .lane_ok (lane_ok),
        .result  (result)
    );

    // output register plus skid entry
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = result;
                out_valid_next = accept_in;
            end
        end else if (accept_in) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `BCSC_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, accept_in, m_valid)
    `BCSC_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `BCSC_ASSERT_NEXT(a_cfg_min_written, aclk, aresetn, cfg_valid && cfg_index == bcsc_pkg::CFG_CELL_MIN, cfg_reg.cell_min_mv == $past(cfg_data))

endmodule

FILE: rtl/bcsc_cell_lane.sv
// One cell lane: checks a cell voltage against the configured window.
module bcsc_cell_lane (
    input  logic [bcsc_pkg::CELL_W-1:0] cell_mv,
    input  logic [bcsc_pkg::CELL_W-1:0] min_mv,
    input  logic [bcsc_pkg::CELL_W-1:0] max_mv,
    output logic                        in_window
);

    assign in_window = (cell_mv >= min_mv) && (cell_mv <= max_mv);

endmodule

FILE: rtl/bcsc_fsm.sv
// Charge state machine with lane merge and permit forcing.
`include "battery_charge_state_controller_macros.svh"

module bcsc_fsm #(
    parameter int CELL_COUNT = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  bcsc_pkg::in_item_t     item,
    input  bcsc_pkg::cfg_t         cfg,
    input  logic [CELL_COUNT-1:0]  lane_ok,
    output bcsc_pkg::out_item_t    result
);

    bcsc_pkg::state_t state_reg;
    bcsc_pkg::state_t state_next;
    bcsc_pkg::state_t target;
    logic             cells_ok;
    logic             critical;
    logic             link_ok;
    logic             wants;
    logic             above_detect;
    logic             below_stop;
    logic             permit;

    // merge of the lane results, fault masks, charge request and current thresholds
    assign cells_ok     = &lane_ok;
    assign critical     = |(item.fault_flags & cfg.critical_fault_mask);
    assign link_ok      = ~|(item.fault_flags & cfg.link_timeout_mask);
    assign wants        = item.charge_request && item.charger_connected && !item.emergency_stop;
    assign above_detect = item.pack_current_ma > $signed({1'b0, cfg.charge_on_ma});
    assign below_stop   = item.pack_current_ma < $signed({1'b0, cfg.charge_off_ma});

    always_comb begin
        target = state_reg;
        unique case (state_reg)
            bcsc_pkg::ST_INIT: begin
                target = bcsc_pkg::ST_SELF_CHECK;
            end
            bcsc_pkg::ST_SELF_CHECK: begin
                target = (item.sensors_ready && cells_ok) ? bcsc_pkg::ST_IDLE
                                                          : bcsc_pkg::ST_FAULT;
            end
            bcsc_pkg::ST_IDLE: begin
                priority if (critical) begin
                    target = bcsc_pkg::ST_FAULT;
                end else if (item.permit_request && link_ok && wants) begin
                    target = bcsc_pkg::ST_CHARGE_READY;
                end else begin
                    target = bcsc_pkg::ST_IDLE;
                end
            end
            bcsc_pkg::ST_CHARGE_READY: begin
                priority if (critical) begin
                    target = bcsc_pkg::ST_FAULT;
                end else if (above_detect) begin
                    target = bcsc_pkg::ST_CHARGING;
                end else if (!link_ok || !wants) begin
                    target = bcsc_pkg::ST_IDLE;
                end else begin
                    target = bcsc_pkg::ST_CHARGE_READY;
                end
            end
            bcsc_pkg::ST_CHARGING: begin
                priority if (critical) begin
                    target = bcsc_pkg::ST_FAULT;
                end else if (!wants || below_stop) begin
                    target = bcsc_pkg::ST_IDLE;
                end else begin
                    target = bcsc_pkg::ST_CHARGING;
                end
            end
            bcsc_pkg::ST_FAULT: begin
                target = critical ? bcsc_pkg::ST_FAULT : bcsc_pkg::ST_IDLE;
            end
            default: begin
                target = bcsc_pkg::ST_FAULT;
            end
        endcase
    end

    always_comb begin
        state_next = advance ? target : state_reg;
    end

    always_comb begin
        permit = item.permit_request;
        if (state_reg != bcsc_pkg::ST_INIT && state_reg != bcsc_pkg::ST_SELF_CHECK &&
            state_reg != bcsc_pkg::ST_IDLE && state_reg != bcsc_pkg::ST_CHARGE_READY &&
            state_reg != bcsc_pkg::ST_CHARGING) begin
            permit = 1'b0;
        end
        if (target != state_reg && target != bcsc_pkg::ST_CHARGE_READY &&
            target != bcsc_pkg::ST_CHARGING) begin
            permit = 1'b0;
        end
        result.fsm_state      = target;
        result.permit_granted = permit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bcsc_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    `BCSC_ASSERT_NEXT(a_init_to_check, aclk, aresetn, advance && state_reg == bcsc_pkg::ST_INIT, state_reg == bcsc_pkg::ST_SELF_CHECK)
    `BCSC_ASSERT_NEXT(a_hold_when_idle, aclk, aresetn, !advance, $stable(state_reg))
    `BCSC_ASSERT(a_fault_no_permit, aclk, aresetn, (state_reg == bcsc_pkg::ST_FAULT) |-> !result.permit_granted)

endmodule
